/* hw/rtl/tawh_pkg.sv */
// Shared types, constants and the tangent table of the tilt alarm block.
package tawh_pkg;

  localparam int WINDOW      = 16;
  localparam int CNT_W       = $clog2(WINDOW + 1);
  localparam int SLOT_W      = $clog2(WINDOW);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int AXIS_W      = 16;
  localparam int ANGLE_W     = 8;
  localparam int P_W         = 7;
  localparam int PCT_W       = 7;
  localparam int MS_W        = 16;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 2;

  localparam int NUM_TAN     = 44;
  localparam int IDX_W       = 6;
  localparam int TAN_W       = 47;
  localparam int TAN_SPLIT   = 24;
  localparam int CMP_W       = 63;
  localparam int SCALE_SHIFT = 14;
  localparam int LO_PROD_W   = AXIS_W + TAN_SPLIT;
  localparam int HI_PROD_W   = AXIS_W + TAN_W - TAN_SPLIT;
  localparam int SCL_PROD_W  = 49;
  localparam logic [32:0] FIVE_POW14 = 33'd6103515625;

  localparam int LEVEL_N_W   = $clog2(WINDOW * 100 + 1);
  localparam int RECIP_SHIFT = 19;
  localparam int RECIP_W     = 13;
  localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;
  localparam int LEVEL_P_W   = LEVEL_N_W + RECIP_W;

  localparam logic [P_W-1:0]     P_FLAT      = 7'd0;
  localparam logic [P_W-1:0]     P_DIAG      = 7'd45;
  localparam logic [P_W-1:0]     P_UPRIGHT   = 7'd90;
  localparam logic [P_W-1:0]     P_MIRROR    = 7'd89;
  localparam logic [ANGLE_W-1:0] A_HALF_TURN = 8'd180;
  localparam logic [ANGLE_W-1:0] A_HALF_LESS = 8'd179;
  localparam logic [PCT_W-1:0]   PCT_FULL    = 7'd100;

  localparam logic [CFG_IDX_W-1:0] CFG_ALERT_ANGLE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALERT_PERCENT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLINK_MS      = 2'd2;

  localparam logic [ANGLE_W-1:0] RST_ALERT_ANGLE   = 8'd20;
  localparam logic [PCT_W-1:0]   RST_ALERT_PERCENT = 7'd70;
  localparam logic [MS_W-1:0]    RST_BLINK_MS      = 16'd500;

  typedef struct packed {
    logic              x_neg;
    logic              search;
    logic [P_W-1:0]    fixed_p;
    logic              a_lt_b;
    logic [AXIS_W-1:0] lo;
    logic [AXIS_W-1:0] hi;
    logic [MS_W-1:0]   elapsed;
  } tawh_item_t;

  // tan(d+1 degrees) scaled by 10^14
  function automatic logic [TAN_W-1:0] tan_value(input logic [IDX_W-1:0] idx);
    logic [TAN_W-1:0] t;
    case (idx)
      6'd0:  t = 47'd1745506492822;
      6'd1:  t = 47'd3492076949175;
      6'd2:  t = 47'd5240777928304;
      6'd3:  t = 47'd6992681194351;
      6'd4:  t = 47'd8748866352592;
      6'd5:  t = 47'd10510423526568;
      6'd6:  t = 47'd12278456090290;
      6'd7:  t = 47'd14054083470239;
      6'd8:  t = 47'd15838444032454;
      6'd9:  t = 47'd17632698070846;
      6'd10: t = 47'd19438030913772;
      6'd11: t = 47'd21255656167002;
      6'd12: t = 47'd23086819112556;
      6'd13: t = 47'd24932800284318;
      6'd14: t = 47'd26794919243112;
      6'd15: t = 47'd28674538575881;
      6'd16: t = 47'd30573068145866;
      6'd17: t = 47'd32491969623291;
      6'd18: t = 47'd34432761328967;
      6'd19: t = 47'd36397023426620;
      6'd20: t = 47'd38386403503542;
      6'd21: t = 47'd40402622583516;
      6'd22: t = 47'd42447481620960;
      6'd23: t = 47'd44522868530854;
      6'd24: t = 47'd46630765815500;
      6'd25: t = 47'd48773258856586;
      6'd26: t = 47'd50952544949443;
      6'd27: t = 47'd53170943166148;
      6'd28: t = 47'd55430905145277;
      6'd29: t = 47'd57735026918963;
      6'd30: t = 47'd60086061902756;
      6'd31: t = 47'd62486935190933;
      6'd32: t = 47'd64940759319751;
      6'd33: t = 47'd67450851684243;
      6'd34: t = 47'd70020753820971;
      6'd35: t = 47'd72654252800536;
      6'd36: t = 47'd75355405010279;
      6'd37: t = 47'd78128562650672;
      6'd38: t = 47'd80978403319501;
      6'd39: t = 47'd83909963117728;
      6'd40: t = 47'd86928673781623;
      6'd41: t = 47'd90040404429784;
      6'd42: t = 47'd93251508613766;
      6'd43: t = 47'd96568877480707;
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage

/* hw/rtl/tawh_front.sv */
// Input side: takes samples, folds the axes to magnitudes and sorts them into angle classes.
module tawh_front (
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [47:0]                s_tdata,   // accel_x, accel_z, elapsed_ms
  input  logic                       queue_full,
  output logic                       push,
  output tawh_pkg::tawh_item_t       push_item
);
  import tawh_pkg::*;

  logic [AXIS_W-1:0] raw_x;
  logic [AXIS_W-1:0] raw_z;
  logic [AXIS_W-1:0] mag_a;
  logic [AXIS_W-1:0] mag_b;
  logic              a_lt_b;

  assign raw_x    = s_tdata[15:0];
  assign raw_z    = s_tdata[31:16];
  assign mag_b    = raw_x[AXIS_W-1] ? AXIS_W'(~raw_x + 16'd1) : raw_x;
  assign mag_a    = raw_z[AXIS_W-1] ? AXIS_W'(~raw_z + 16'd1) : raw_z;
  assign a_lt_b   = mag_a < mag_b;

  assign s_tready = !queue_full;
  assign push     = s_tvalid && !queue_full;

  always_comb begin
    push_item.x_neg   = raw_x[AXIS_W-1];
    push_item.a_lt_b  = a_lt_b;
    push_item.lo      = a_lt_b ? mag_a : mag_b;
    push_item.hi      = a_lt_b ? mag_b : mag_a;
    push_item.elapsed = s_tdata[47:32];
    push_item.search  = 1'b0;
    if (mag_a == '0) begin
      push_item.fixed_p = P_FLAT;
    end else if (mag_b == '0) begin
      push_item.fixed_p = P_UPRIGHT;
    end else if (mag_a == mag_b) begin
      push_item.fixed_p = P_DIAG;
    end else begin
      push_item.fixed_p = P_FLAT;
      push_item.search  = 1'b1;
    end
  end

endmodule

/* hw/rtl/tawh_queue.sv */
// Short queue of classified samples between the input side and the angle engine.
module tawh_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  tawh_pkg::tawh_item_t push_item,
  input  logic                 pop,
  output tawh_pkg::tawh_item_t head,
  output logic                 empty,
  output logic                 full
);
  import tawh_pkg::*;

  tawh_item_t        slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign empty = count == '0;
  assign full  = count == QCNT_W'(QUEUE_DEPTH);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  assert property (@(posedge clk) disable iff (rst) full |-> !push)
    else $error("queue overrun");
  assert property (@(posedge clk) disable iff (rst) empty |-> !pop)
    else $error("queue underrun");
  assert property (@(posedge clk) disable iff (rst) count <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count out of range");

endmodule

/* hw/rtl/tawh_back.sv */
// Angle engine with tangent search, mark window, hysteresis flag, LED and output register.
module tawh_back (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [tawh_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tawh_pkg::CFG_W-1:0]      cfg_data,
  input  tawh_pkg::tawh_item_t            head,
  input  logic                            empty,
  output logic                            pop,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [7:0]                      m_tdata,  // angle_deg
  output logic [1:0]                      m_tuser   // tilted, led_on
);
  import tawh_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_PREP   = 6'b000010,
    S_MUL_LO = 6'b000100,
    S_MUL_HI = 6'b001000,
    S_CMP    = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  state_t             state;
  tawh_item_t         cur;

  logic [ANGLE_W-1:0] alert_angle;
  logic [PCT_W-1:0]   alert_percent;
  logic [MS_W-1:0]    blink_interval_ms;

  logic [PCT_W-1:0]     pct_c;
  logic [LEVEL_N_W-1:0] on_n;
  logic [LEVEL_N_W-1:0] off_n;
  logic [LEVEL_P_W-1:0] on_prod;
  logic [LEVEL_P_W-1:0] off_prod;
  logic [CNT_W-1:0]     on_level;
  logic [CNT_W-1:0]     off_level;

  logic [IDX_W-1:0]     bs_lo;
  logic [IDX_W-1:0]     bs_hi;
  logic [IDX_W-1:0]     mid;
  logic [IDX_W-1:0]     idx;
  logic [TAN_W-1:0]     tan_word;
  logic [CMP_W-1:0]     l_word;
  logic [LO_PROD_W-1:0] prod_lo;
  logic [HI_PROD_W-1:0] prod_hi;
  logic [CMP_W-1:0]     rhs;
  logic                 pass;
  logic [IDX_W-1:0]     bs_lo_next;
  logic [IDX_W-1:0]     bs_hi_next;
  logic [SCL_PROD_W-1:0] scaled_lo;

  logic [WINDOW-1:0]  marks;
  logic [SLOT_W-1:0]  write_slot;
  logic [CNT_W-1:0]   mark_count;
  logic               alarm_flag;
  logic               led_level;

  logic [P_W-1:0]     p_val;
  logic [ANGLE_W-1:0] angle;
  logic               mark;
  logic [CNT_W-1:0]   mark_count_next;
  logic               alarm_flag_next;
  logic               led_level_next;
  logic               retire;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      alert_angle       <= RST_ALERT_ANGLE;
      alert_percent     <= RST_ALERT_PERCENT;
      blink_interval_ms <= RST_BLINK_MS;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_ALERT_ANGLE:   alert_angle       <= cfg_data[ANGLE_W-1:0];
        CFG_ALERT_PERCENT: alert_percent     <= cfg_data[PCT_W-1:0];
        CFG_BLINK_MS:      blink_interval_ms <= cfg_data[MS_W-1:0];
        default: ;
      endcase
    end
  end

  // hysteresis thresholds floor(WINDOW*pct/100), off with 100-pct, by reciprocal multiply
  assign pct_c    = (alert_percent > PCT_FULL) ? PCT_FULL : alert_percent;
  assign on_prod  = LEVEL_P_W'(on_n) * LEVEL_P_W'(RECIP_100);
  assign off_prod = LEVEL_P_W'(off_n) * LEVEL_P_W'(RECIP_100);

  always_ff @(posedge clk) begin
    on_n      <= LEVEL_N_W'(pct_c) * LEVEL_N_W'(WINDOW);
    off_n     <= LEVEL_N_W'(PCT_FULL - pct_c) * LEVEL_N_W'(WINDOW);
    on_level  <= on_prod[RECIP_SHIFT +: CNT_W];
    off_level <= off_prod[RECIP_SHIFT +: CNT_W];
  end

  // tangent search datapath
  assign mid       = IDX_W'((7'(bs_lo) + 7'(bs_hi) + 7'd1) >> 1);
  assign idx       = mid - 1'b1;
  assign tan_word  = tan_value(idx);
  assign rhs       = CMP_W'(prod_lo) + (CMP_W'(prod_hi) << TAN_SPLIT);
  assign pass      = l_word >= rhs;
  assign bs_lo_next = pass ? mid : bs_lo;
  assign bs_hi_next = pass ? bs_hi : mid - 1'b1;
  assign scaled_lo = SCL_PROD_W'(cur.lo) * SCL_PROD_W'(FIVE_POW14);

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (!empty) begin
          cur <= head;
        end
      end
      S_PREP: begin
        l_word <= CMP_W'(scaled_lo) << SCALE_SHIFT;
        bs_lo  <= '0;
        bs_hi  <= IDX_W'(NUM_TAN);
      end
      S_MUL_LO: prod_lo <= LO_PROD_W'(cur.hi) * LO_PROD_W'(tan_word[TAN_SPLIT-1:0]);
      S_MUL_HI: prod_hi <= HI_PROD_W'(cur.hi) * HI_PROD_W'(tan_word[TAN_W-1:TAN_SPLIT]);
      S_CMP: begin
        bs_lo <= bs_lo_next;
        bs_hi <= bs_hi_next;
      end
      default: ;
    endcase
  end

  // angle, mark, window, flag and LED update
  always_comb begin
    if (cur.search) begin
      p_val = cur.a_lt_b ? P_W'(bs_lo) : P_MIRROR - P_W'(bs_lo);
    end else begin
      p_val = cur.fixed_p;
    end
    if (!cur.x_neg) begin
      angle = ANGLE_W'(p_val);
    end else if (cur.search) begin
      angle = A_HALF_LESS - ANGLE_W'(p_val);
    end else begin
      angle = A_HALF_TURN - ANGLE_W'(p_val);
    end
    mark            = angle > alert_angle;
    mark_count_next = mark_count - CNT_W'(marks[write_slot]) + CNT_W'(mark);
    alarm_flag_next = alarm_flag ? (mark_count_next > off_level)
                                 : (mark_count_next > on_level);
    if (!alarm_flag_next) begin
      led_level_next = 1'b0;
    end else if (cur.elapsed >= blink_interval_ms) begin
      led_level_next = !led_level;
    end else begin
      led_level_next = led_level;
    end
  end

  assign retire = (state == S_DONE) && (!m_tvalid || m_tready);
  assign pop    = (state == S_IDLE) && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      marks      <= '0;
      write_slot <= '0;
      mark_count <= '0;
      alarm_flag <= 1'b0;
      led_level  <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (retire) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (!empty) begin
            state <= S_PREP;
          end
        end
        S_PREP:   state <= cur.search ? S_MUL_LO : S_DONE;
        S_MUL_LO: state <= S_MUL_HI;
        S_MUL_HI: state <= S_CMP;
        S_CMP:    state <= (bs_lo_next == bs_hi_next) ? S_DONE : S_MUL_LO;
        S_DONE: begin
          if (retire) begin
            marks[write_slot] <= mark;
            write_slot <= (write_slot == SLOT_W'(WINDOW - 1)) ? '0 : write_slot + 1'b1;
            mark_count <= mark_count_next;
            alarm_flag <= alarm_flag_next;
            led_level  <= led_level_next;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (retire) begin
      m_tdata <= angle;
      m_tuser <= {led_level_next, alarm_flag_next};
    end
  end

  assert property (@(posedge clk) disable iff (rst)
      mark_count == CNT_W'($countones(marks)))
    else $error("mark count out of step with window");
  assert property (@(posedge clk) disable iff (rst) led_level |-> alarm_flag)
    else $error("LED lit without alarm");
  assert property (@(posedge clk) disable iff (rst)
      (state == S_MUL_LO) |-> (bs_lo < bs_hi))
    else $error("search bounds collapsed");
  assert property (@(posedge clk) disable iff (rst)
      (m_tvalid && !m_tready) |=> (state != S_IDLE || m_tvalid))
    else $error("result lost while stalled");

endmodule

/* hw/rtl/tilt_alarm_window_hysteresis.sv */
// Top level of the tilt alarm with majority-window hysteresis and blinking LED.
//
// Input stream (s_t*): one accelerometer sample per transfer, tdata holds
// accel_x [15:0], accel_z [31:16] and elapsed_ms [47:32].
// Output stream (m_t*): one result per sample, tdata holds angle_deg [7:0],
// tuser holds tilted [0] and led_on [1].
// Configuration: cfg_write with cfg_index 0 alert_angle, 1 alert_percent,
// 2 blink_interval_ms; write only while no sample is in flight.
// The angle engine takes flat, upright, diagonal or zero samples straight
// from S_PREP to S_DONE; other samples run a binary search over the 44
// tangent boundaries in 5 or 6 steps. Each step passes through S_MUL_LO and
// S_MUL_HI, which form a 16x24 and a 16x23 partial product, and S_CMP. One
// sample is in the angle engine at a time, so the engine does not take a new
// sample before it has retired the last one.
// A two-entry queue lets the input side take samples while the engine works.
// Reset clears the mark window, the count, the alarm flag, the LED and both
// streams, and restores the default configuration. When the receiver stalls
// the result holds, the engine waits to retire and the queue fills up.
module tilt_alarm_window_hysteresis (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [tawh_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tawh_pkg::CFG_W-1:0]      cfg_data,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [47:0]                     s_tdata,  // accel_x, accel_z, elapsed_ms
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [7:0]                      m_tdata,  // angle_deg
  output logic [1:0]                      m_tuser   // tilted, led_on
);
  import tawh_pkg::*;

  tawh_item_t push_item;
  tawh_item_t head;
  logic       push;
  logic       pop;
  logic       empty;
  logic       full;

  tawh_front u_front (
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .queue_full (full),
    .push       (push),
    .push_item  (push_item)
  );

  tawh_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .empty     (empty),
    .full      (full)
  );

  tawh_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .head      (head),
    .empty     (empty),
    .pop       (pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule

/* verif/tb_top.sv */
// Self-checking testbench of the tilt alarm: directed edge cases, then random samples per setting.
`timescale 1ns / 1ps

module tb_top;
  import tawh_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASE_ITEMS  = 240;
  localparam int PHASES       = 8;
  localparam int DRAIN_CYCLES = 30;

  typedef struct packed {
    logic [7:0] angle;
    logic       tilted;
    logic       led;
  } tilt_result_t;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] z;
    logic [15:0] ms;
    logic        lit;
    logic [7:0]  angle;
    logic        tilted;
    logic        led;
  } sample_row_t;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_ALERT_ANGLE;
  logic [CFG_W-1:0]     cfg_data  = '0;
  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  logic [47:0]          s_tdata   = '0;
  logic                 m_tvalid;
  logic                 m_tready  = 1'b0;
  logic [7:0]           m_tdata;
  logic [1:0]           m_tuser;

  tilt_alarm_window_hysteresis i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  // tan(1..44 degrees) scaled by 10^14
  longint unsigned tan_e14 [44] = '{
    64'd1745506492822,  64'd3492076949175,  64'd5240777928304,  64'd6992681194351,
    64'd8748866352592,  64'd10510423526568, 64'd12278456090290, 64'd14054083470239,
    64'd15838444032454, 64'd17632698070846, 64'd19438030913772, 64'd21255656167002,
    64'd23086819112556, 64'd24932800284318, 64'd26794919243112, 64'd28674538575881,
    64'd30573068145866, 64'd32491969623291, 64'd34432761328967, 64'd36397023426620,
    64'd38386403503542, 64'd40402622583516, 64'd42447481620960, 64'd44522868530854,
    64'd46630765815500, 64'd48773258856586, 64'd50952544949443, 64'd53170943166148,
    64'd55430905145277, 64'd57735026918963, 64'd60086061902756, 64'd62486935190933,
    64'd64940759319751, 64'd67450851684243, 64'd70020753820971, 64'd72654252800536,
    64'd75355405010279, 64'd78128562650672, 64'd80978403319501, 64'd83909963117728,
    64'd86928673781623, 64'd90040404429784, 64'd93251508613766, 64'd96568877480707
  };

  // x, z, elapsed, typed-in flag, angle, tilted, led
  sample_row_t directed_rows [22] = '{
    '{16'sd0,       16'sd0,       16'd0,     1'b1, 8'd0,   1'b0, 1'b0},
    '{16'sd100,     16'sd0,       16'd0,     1'b1, 8'd0,   1'b0, 1'b0},
    '{-16'sd100,    16'sd0,       16'd0,     1'b1, 8'd180, 1'b0, 1'b0},
    '{16'sd0,       16'sd100,     16'd65535, 1'b1, 8'd90,  1'b0, 1'b0},
    '{16'sd0,       -16'sd100,    16'd0,     1'b1, 8'd90,  1'b0, 1'b0},
    '{16'sd50,      16'sd50,      16'd0,     1'b1, 8'd45,  1'b0, 1'b0},
    '{-16'sd50,     16'sd50,      16'd0,     1'b1, 8'd135, 1'b0, 1'b0},
    '{16'sh8000,    16'sd0,       16'd0,     1'b1, 8'd180, 1'b0, 1'b0},
    '{16'sd32767,   16'sd0,       16'd65535, 1'b1, 8'd0,   1'b0, 1'b0},
    '{16'sd0,       16'sh8000,    16'd0,     1'b1, 8'd90,  1'b0, 1'b0},
    '{16'sh8000,    16'sh8000,    16'd0,     1'b1, 8'd135, 1'b0, 1'b0},
    '{16'sd32767,   16'sd32767,   16'd0,     1'b1, 8'd45,  1'b0, 1'b0},
    '{16'sd32767,   16'sh8000,    16'd0,     1'b0, 8'd0,   1'b0, 1'b0},
    '{-16'sd1,      16'sd1,       16'd0,     1'b1, 8'd135, 1'b0, 1'b0},
    '{16'sd1000,    16'sd364,     16'd0,     1'b0, 8'd0,   1'b0, 1'b0},
    '{-16'sd1,      16'sd0,       16'd0,     1'b0, 8'd0,   1'b0, 1'b0},
    '{16'sd3,       16'sd4,       16'd500,   1'b0, 8'd0,   1'b0, 1'b0},
    '{-16'sd3,      -16'sd4,      16'd499,   1'b0, 8'd0,   1'b0, 1'b0},
    '{16'sd4,       16'sd3,       16'd65535, 1'b0, 8'd0,   1'b0, 1'b0},
    '{16'sd1000,    -16'sd365,    16'd500,   1'b0, 8'd0,   1'b0, 1'b0},
    '{16'sh8000,    16'sd1,       16'd0,     1'b0, 8'd0,   1'b0, 1'b0},
    '{16'sd1,       16'sh8000,    16'd0,     1'b0, 8'd0,   1'b0, 1'b0}
  };

  int phase_angle [6] = '{20, 0, 180, 255, 45, 90};
  int phase_pct   [6] = '{70, 50, 100, 127, 30, 60};
  int phase_blink [6] = '{500, 0, 65535, 1, 1000, 100};
  int axis_edges  [5] = '{0, 1, -1, 32767, -32768};

  tilt_result_t expected_q [$];
  int           errors     = 0;
  int           send_idle  = 0;
  int           stall_pct  = 0;

  int           alert_angle_q = 20;
  int           alert_pct_q   = 70;
  int           blink_ms_q    = 500;
  bit [15:0]    mark_ring     = '0;
  bit [3:0]     ring_slot     = '0;
  int           mark_total    = 0;
  bit           alarm_q       = 1'b0;
  bit           led_q         = 1'b0;

  function automatic tilt_result_t predict_sample(logic signed [15:0] x, logic signed [15:0] z,
                                                  logic [15:0] ms);
    int              xs;
    int              zs;
    longint unsigned a;
    longint unsigned b;
    longint unsigned lo;
    longint unsigned hi;
    int              f;
    int              p;
    int              angle;
    int              pct;
    int              on_level;
    int              off_level;
    bit              exact;
    bit              mark;
    tilt_result_t    r;
    xs = x;
    zs = z;
    b = 64'((xs < 0) ? -xs : xs);
    a = 64'((zs < 0) ? -zs : zs);
    exact = 1'b1;
    if (a == 0) begin
      p = 0;
    end else if (b == 0) begin
      p = 90;
    end else if (a == b) begin
      p = 45;
    end else begin
      lo = (a < b) ? a : b;
      hi = (a < b) ? b : a;
      f = 0;
      for (int d = 0; d < 44; d++)
        if (lo * 64'd100000000000000 >= hi * tan_e14[d])
          f++;
      p = (a < b) ? f : 89 - f;
      exact = 1'b0;
    end
    if (xs >= 0)
      angle = p;
    else
      angle = exact ? 180 - p : 179 - p;

    mark = angle > alert_angle_q;
    pct = (alert_pct_q > 100) ? 100 : alert_pct_q;
    on_level = 16 * pct / 100;
    off_level = 16 * (100 - pct) / 100;
    if (mark_ring[ring_slot] && mark_total > 0)
      mark_total--;
    mark_ring[ring_slot] = mark;
    if (mark)
      mark_total++;
    ring_slot++;

    if (alarm_q)
      alarm_q = mark_total > off_level;
    else
      alarm_q = mark_total > on_level;
    if (!alarm_q)
      led_q = 1'b0;
    else if (ms >= blink_ms_q)
      led_q = ~led_q;

    r.angle = angle[7:0];
    r.tilted = alarm_q;
    r.led = led_q;
    return r;
  endfunction

  task automatic send_sample(input sample_row_t row);
    tilt_result_t want;
    while ($urandom_range(0, 99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {row.ms, row.z, row.x};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    want = predict_sample(row.x, row.z, row.ms);
    if (row.lit)
      want = '{row.angle, row.tilted, row.led};
    expected_q.push_back(want);
  endtask

  task automatic program_cfg(input int ang, input int pct, input int blink);
    cfg_write <= 1'b1;
    cfg_index <= CFG_ALERT_ANGLE;
    cfg_data <= CFG_W'(ang);
    @(posedge clk);
    cfg_index <= CFG_ALERT_PERCENT;
    cfg_data <= CFG_W'(pct);
    @(posedge clk);
    cfg_index <= CFG_BLINK_MS;
    cfg_data <= CFG_W'(blink);
    @(posedge clk);
    cfg_write <= 1'b0;
    alert_angle_q = ang;
    alert_pct_q = pct;
    blink_ms_q = blink;
  endtask

  task automatic drain_results();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    int cycle_count;
    for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++)
      @(posedge clk);
    $display("simulation failed");
    $finish;
  end

  always @(posedge clk) begin
    tilt_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: result with none expected: angle_deg %0d tilted %0b led_on %0b",
                 $time, m_tdata, m_tuser[0], m_tuser[1]);
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (m_tdata !== want.angle) begin
          $display("%0t: angle_deg expected %0d actual %0d", $time, want.angle, m_tdata);
          errors++;
        end
        if (m_tuser[0] !== want.tilted) begin
          $display("%0t: tilted expected %0b actual %0b", $time, want.tilted, m_tuser[0]);
          errors++;
        end
        if (m_tuser[1] !== want.led) begin
          $display("%0t: led_on expected %0b actual %0b", $time, want.led, m_tuser[1]);
          errors++;
        end
      end
    end
    m_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  initial begin
    sample_row_t row;
    int          pick;
    int          xs;
    int          zs;
    int          big;
    int          run_left;
    bit          run_tilted;
    int          ang;
    int          pct;
    int          blink;
    run_left = 0;
    run_tilted = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset configuration, no idling
    foreach (directed_rows[i])
      send_sample(directed_rows[i]);
    s_tvalid <= 1'b0;

    for (int phase = 0; phase < PHASES; phase++) begin
      drain_results();
      if (phase < 6) begin
        ang = phase_angle[phase];
        pct = phase_pct[phase];
        blink = phase_blink[phase];
      end else begin
        ang = $urandom_range(0, 255);
        pct = $urandom_range(0, 127);
        blink = $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535) : $urandom_range(0, 600);
      end
      program_cfg(ang, pct, blink);
      case (phase % 4)
        0: begin send_idle = 0;  stall_pct = 0;  end
        1: begin send_idle = 70; stall_pct = 0;  end
        2: begin send_idle = 0;  stall_pct = 70; end
        default: begin send_idle = 7; stall_pct = 7; end
      endcase

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
          row.x = 16'(axis_edges[$urandom_range(0, 4)]);
          row.z = 16'(axis_edges[$urandom_range(0, 4)]);
        end else if (pick < 35) begin
          row.x = 16'($urandom);
          row.z = 16'($urandom);
        end else begin
          // hold a tilted or a level run so the count crosses both bands
          if (run_left == 0) begin
            run_tilted = 1'($urandom_range(0, 1));
            run_left = $urandom_range(4, 30);
          end
          run_left--;
          big = $urandom_range(1, 32767) >> $urandom_range(0, 12);
          if (big == 0)
            big = 1;
          if (run_tilted) begin
            zs = big;
            xs = big * $urandom_range(0, 255) / 256;
            if ($urandom_range(0, 1))
              xs = -xs;
          end else begin
            xs = big;
            zs = big * $urandom_range(0, 255) / 1024;
          end
          if ($urandom_range(0, 1))
            zs = -zs;
          row.x = 16'(xs);
          row.z = 16'(zs);
        end
        case ($urandom_range(0, 9))
          0, 1:    row.ms = '0;
          2, 3:    row.ms = 16'(blink_ms_q + $urandom_range(0, 2) - 1);
          4:       row.ms = 16'hFFFF;
          default: row.ms = 16'($urandom);
        endcase
        row.lit = 1'b0;
        row.angle = '0;
        row.tilted = 1'b0;
        row.led = 1'b0;
        send_sample(row);
      end
      s_tvalid <= 1'b0;
    end

    drain_results();
    if (errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

/* tilt_alarm_window_hysteresis.f */
hw/rtl/tawh_pkg.sv
hw/rtl/tawh_front.sv
hw/rtl/tawh_queue.sv
hw/rtl/tawh_back.sv
hw/rtl/tilt_alarm_window_hysteresis.sv
verif/tb_top.sv
